/* hw/rtl/uuid_text_parser_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the UUID text parser
// Shared shorthand for clocked checks with reset disable.
// ---------------------------------------------------------------------------
`ifndef UUID_TEXT_PARSER_MACROS_SVH
`define UUID_TEXT_PARSER_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define UTP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utp same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define UTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utp next-cycle check failed");

`endif

/* hw/rtl/utp_pkg.sv */
// ---------------------------------------------------------------------------
// UUID text parser package
// Item types, parse operation format and character constants.
// ---------------------------------------------------------------------------
package utp_pkg;

  localparam int POS_W = 6;
  localparam logic [POS_W-1:0] POS_END  = 6'd36;
  localparam logic [POS_W-1:0] POS_IDLE = 6'd37;

  localparam logic [7:0] DASH_CHAR = 8'h2d;
  localparam logic [7:0] NUL_CHAR  = 8'h00;

  typedef struct packed {
    logic [7:0] char_code;
    logic       first_char;
  } in_item_t;

  typedef struct packed {
    logic [31:0] time_low;
    logic [15:0] time_mid;
    logic [15:0] time_hi_version;
    logic [15:0] clock_seq;
    logic [47:0] node;
    logic        format_status;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_LOW,
    OP_MID,
    OP_HI,
    OP_CLK,
    OP_NODE,
    OP_DASH,
    OP_END
  } op_kind_t;

  // One classified character handed from the front to the back.
  typedef struct packed {
    logic       start;
    op_kind_t   kind;
    logic [3:0] nibble;
    logic [1:0] slot;
    logic       bad;
  } op_t;

  // Returns {not_hex, nibble}; the nibble is zero for a non-hex character.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] res;
    res = 5'b10000;
    if (c inside {[8'h30:8'h39]}) begin
      res = {1'b0, c[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      res = {1'b0, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      res = {1'b0, 4'(c - 8'h57)};
    end
    return res;
  endfunction

endpackage

/* hw/rtl/utp_fifo.sv */
// ---------------------------------------------------------------------------
// UUID text parser queue
// Small first-in first-out register queue with full and empty flags.
// ---------------------------------------------------------------------------
module utp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

`include "uuid_text_parser_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             wr_en;
  logic             rd_en;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign wr_en   = push && !full;
  assign rd_en   = pop && !empty;
  assign rd_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

  `UTP_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_FULL)
  `UTP_ASSERT_NEXT(a_push_fills, wr_en && !rd_en, !empty)
  `UTP_ASSERT_NEXT(a_last_pop_drains, rd_en && !wr_en && (count_r == 1), empty)

endmodule

/* hw/rtl/utp_front.sv */
// ---------------------------------------------------------------------------
// UUID text parser front end
// Tracks the character position and classifies each character.
// ---------------------------------------------------------------------------
module utp_front
  import utp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output logic     op_push,
  output op_t      op
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pos_cur;
  logic             ignore;
  logic [4:0]       hex;

  assign pos_cur = item.first_char ? '0 : pos_r;
  // Characters outside a string (after reset or past the terminator) are dropped.
  assign ignore  = !item.first_char && (pos_r >= POS_IDLE);
  assign op_push = accept && !ignore;
  assign hex     = hex_decode(item.char_code);

  always_comb begin
    op.start  = item.first_char;
    op.kind   = OP_NODE;
    op.nibble = hex[3:0];
    op.slot   = 2'd0;
    op.bad    = hex[4];
    if (pos_cur == POS_END) begin
      op.kind = OP_END;
      op.bad  = (item.char_code != NUL_CHAR);
    end else if (pos_cur inside {6'd8, 6'd13, 6'd18, 6'd23}) begin
      op.kind = OP_DASH;
      op.bad  = (item.char_code != DASH_CHAR);
    end else if (pos_cur < 6'd8) begin
      op.kind = OP_LOW;
    end else if (pos_cur < 6'd13) begin
      op.kind = OP_MID;
    end else if (pos_cur < 6'd18) begin
      op.kind = OP_HI;
    end else if (pos_cur < 6'd23) begin
      // The clock sequence is byte-swapped: pick the nibble slot directly.
      op.kind = OP_CLK;
      case (pos_cur)
        6'd19:   op.slot = 2'd1;
        6'd20:   op.slot = 2'd0;
        6'd21:   op.slot = 2'd3;
        default: op.slot = 2'd2;
      endcase
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (op_push) begin
      pos_nxt = (pos_cur == POS_END) ? POS_IDLE : pos_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_IDLE;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

/* hw/rtl/utp_back.sv */
// ---------------------------------------------------------------------------
// UUID text parser back end
// Applies classified characters to the field accumulators and emits results.
// ---------------------------------------------------------------------------
module utp_back
  import utp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      op_valid,
  input  op_t       op,
  output logic      op_pop,
  input  logic      res_full,
  output logic      res_push,
  output out_item_t res
);

  logic        err_r, err_nxt;
  logic [31:0] low_r, low_nxt;
  logic [15:0] mid_r, mid_nxt;
  logic [15:0] hi_r, hi_nxt;
  logic [15:0] clk_r, clk_nxt;
  logic [47:0] node_r, node_nxt;

  logic        err_b;
  logic [31:0] low_b;
  logic [15:0] mid_b;
  logic [15:0] hi_b;
  logic [15:0] clk_b;
  logic [47:0] node_b;
  logic        is_end;

  assign is_end   = (op.kind == OP_END);
  // The terminator waits for room in the result queue; other items never stall.
  assign op_pop   = op_valid && !(is_end && res_full);
  assign res_push = op_pop && is_end;

  always_comb begin
    // A start character works on cleared accumulators.
    err_b  = op.start ? 1'b0  : err_r;
    low_b  = op.start ? '0    : low_r;
    mid_b  = op.start ? '0    : mid_r;
    hi_b   = op.start ? '0    : hi_r;
    clk_b  = op.start ? '0    : clk_r;
    node_b = op.start ? '0    : node_r;

    err_nxt  = err_b | op.bad;
    low_nxt  = low_b;
    mid_nxt  = mid_b;
    hi_nxt   = hi_b;
    clk_nxt  = clk_b;
    node_nxt = node_b;
    case (op.kind)
      OP_LOW:  low_nxt  = {low_b[27:0], op.nibble};
      OP_MID:  mid_nxt  = {mid_b[11:0], op.nibble};
      OP_HI:   hi_nxt   = {hi_b[11:0], op.nibble};
      OP_CLK:  clk_nxt[{op.slot, 2'b00} +: 4] = op.nibble;
      OP_NODE: node_nxt = {node_b[43:0], op.nibble};
      default: ;
    endcase

    res.format_status   = err_nxt;
    res.time_low        = err_nxt ? '0 : low_b;
    res.time_mid        = err_nxt ? '0 : mid_b;
    res.time_hi_version = err_nxt ? '0 : hi_b;
    res.clock_seq       = err_nxt ? '0 : clk_b;
    res.node            = err_nxt ? '0 : node_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= 1'b0;
    end else if (op_pop) begin
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      low_r  <= low_nxt;
      mid_r  <= mid_nxt;
      hi_r   <= hi_nxt;
      clk_r  <= clk_nxt;
      node_r <= node_nxt;
    end
  end

endmodule

/* hw/rtl/uuid_text_parser.sv */
// ---------------------------------------------------------------------------
// UUID text parser
// Converts 8-4-4-4-12 UUID text, one character per item, into binary fields.
// ---------------------------------------------------------------------------
// The parser takes one character per clock cycle for as long as the result
// side keeps draining. A front stage tracks the position in the string and
// classifies each character; a queue of OP_DEPTH entries carries it to a
// back stage that updates the field accumulators once per character, at one
// item per cycle unless a terminator waits for room in the result queue.
// The character at position 36 yields one result, flagged in format_status
// if it is not NUL, and held in a result queue of RES_DEPTH entries that
// feeds the result ports. A character with first_char set always restarts
// the string; characters outside a string are dropped without a result.
module uuid_text_parser
  import utp_pkg::*;
#(
  parameter int OP_DEPTH  = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  logic      op_push;
  op_t       op_wr;
  op_t       op_rd;
  logic      op_empty;
  logic      op_pop;
  logic      res_push;
  logic      res_full;
  out_item_t res_wr;
  logic      in_accept;

  assign in_accept = in_push && !in_full;

  utp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .item    (in_item),
    .op_push (op_push),
    .op      (op_wr)
  );

  utp_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (OP_DEPTH)
  ) u_op_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .wr_data (op_wr),
    .full    (in_full),
    .pop     (op_pop),
    .rd_data (op_rd),
    .empty   (op_empty)
  );

  utp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (!op_empty),
    .op       (op_rd),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_wr)
  );

  utp_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

endmodule

/* verif/uuid_field_checker.sv */
// ---------------------------------------------------------------------------
// UUID text parser field checker
// Watches both queue ports of the parser, predicts the binary fields of each
// UUID string from the accepted characters, and compares every popped
// result with the oldest predicted one.
// ---------------------------------------------------------------------------
module uuid_field_checker
  import utp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  logic      in_full,
  input  in_item_t  in_item,
  input  logic      out_pop,
  input  logic      out_empty,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending_results
);

  localparam logic [POS_W-1:0] LOW_END   = 6'd8;
  localparam logic [POS_W-1:0] MID_END   = 6'd13;
  localparam logic [POS_W-1:0] HI_END    = 6'd18;
  localparam logic [POS_W-1:0] CLK_END   = 6'd23;
  localparam logic [POS_W-1:0] CLK_POS_0 = 6'd19;
  localparam logic [POS_W-1:0] CLK_POS_1 = 6'd20;
  localparam logic [POS_W-1:0] CLK_POS_2 = 6'd21;

  logic [POS_W-1:0] pos_q;
  logic             bad_fmt_q;
  logic [31:0]      low_q;
  logic [15:0]      mid_q;
  logic [15:0]      hi_q;
  logic [15:0]      clk_seq_q;
  logic [47:0]      node_q;
  out_item_t        uuid_expected[$];

  task automatic clear_fields();
    bad_fmt_q = 1'b0;
    low_q     = '0;
    mid_q     = '0;
    hi_q      = '0;
    clk_seq_q = '0;
    node_q    = '0;
  endtask

  // Applies one accepted character to the predicted parser state.
  task automatic parse_char(input in_item_t it);
    logic [7:0] c;
    logic [3:0] nib;
    out_item_t  res;
    c = it.char_code;
    if (it.first_char) begin
      pos_q = '0;
      clear_fields();
    end else if (pos_q >= POS_IDLE) begin
      return;
    end
    if (pos_q == POS_END) begin
      if (c != NUL_CHAR) bad_fmt_q = 1'b1;
      res = '0;
      res.format_status = bad_fmt_q;
      if (!bad_fmt_q) begin
        res.time_low        = low_q;
        res.time_mid        = mid_q;
        res.time_hi_version = hi_q;
        res.clock_seq       = clk_seq_q;
        res.node            = node_q;
      end
      uuid_expected.push_back(res);
      pos_q = POS_IDLE;
      return;
    end
    if (pos_q == LOW_END || pos_q == MID_END || pos_q == HI_END || pos_q == CLK_END) begin
      if (c != DASH_CHAR) bad_fmt_q = 1'b1;
    end else begin
      nib = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
        nib = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
        nib = c[3:0] + 4'd9;
      end else begin
        bad_fmt_q = 1'b1;
      end
      if (pos_q < LOW_END) begin
        low_q = {low_q[27:0], nib};
      end else if (pos_q < MID_END) begin
        mid_q = {mid_q[11:0], nib};
      end else if (pos_q < HI_END) begin
        hi_q = {hi_q[11:0], nib};
      end else if (pos_q < CLK_END) begin
        // The clock sequence is byte-swapped: the first pair is the low byte.
        case (pos_q)
          CLK_POS_0: clk_seq_q[7:4]   = nib;
          CLK_POS_1: clk_seq_q[3:0]   = nib;
          CLK_POS_2: clk_seq_q[15:12] = nib;
          default:   clk_seq_q[11:8]  = nib;
        endcase
      end else begin
        node_q = {node_q[43:0], nib};
      end
    end
    pos_q = pos_q + 6'd1;
  endtask

  task automatic check_uuid(input out_item_t got);
    out_item_t exp;
    if (uuid_expected.size() == 0) begin
      $error("unexpected result item: %h", got);
      fail_count++;
      return;
    end
    exp = uuid_expected.pop_front();
    if (got.time_low !== exp.time_low) begin
      $error("time_low: expected %h, got %h", exp.time_low, got.time_low);
      fail_count++;
    end
    if (got.time_mid !== exp.time_mid) begin
      $error("time_mid: expected %h, got %h", exp.time_mid, got.time_mid);
      fail_count++;
    end
    if (got.time_hi_version !== exp.time_hi_version) begin
      $error("time_hi_version: expected %h, got %h", exp.time_hi_version,
             got.time_hi_version);
      fail_count++;
    end
    if (got.clock_seq !== exp.clock_seq) begin
      $error("clock_seq: expected %h, got %h", exp.clock_seq, got.clock_seq);
      fail_count++;
    end
    if (got.node !== exp.node) begin
      $error("node: expected %h, got %h", exp.node, got.node);
      fail_count++;
    end
    if (got.format_status !== exp.format_status) begin
      $error("format_status: expected %b, got %b", exp.format_status, got.format_status);
      fail_count++;
    end
  endtask

  initial begin
    fail_count      = 0;
    pending_results = 0;
    pos_q           = POS_IDLE;
    clear_fields();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pos_q = POS_IDLE;
      clear_fields();
      uuid_expected.delete();
    end else begin
      if (out_pop && !out_empty) check_uuid(out_item);
      if (in_push && !in_full) parse_char(in_item);
    end
    pending_results = uuid_expected.size();
  end

endmodule

/* verif/uuid_text_parser_tb.sv */
// ---------------------------------------------------------------------------
// UUID text parser testbench
// Streams well-formed, corrupted, badly terminated and cut UUID strings into
// the parser under random sender and receiver idling and a long result
// stall; the field checker predicts and compares every result.
// ---------------------------------------------------------------------------
module uuid_text_parser_tb;
  import utp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_CHARS = 520;
  localparam int UUID_LEN    = 37;
  localparam int DRAIN_WAIT  = 20;

  typedef enum int {
    STR_GOOD,
    STR_BAD_CHAR,
    STR_BAD_END,
    STR_CUT
  } str_kind_t;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_pop;
  logic      out_empty;
  out_item_t out_item;

  int fail_count;
  int pending_results;
  int cycle_count;
  int send_idle_pct;
  int take_idle_pct;
  int chars_sent;
  bit hold_req;

  uuid_text_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_item (out_item)
  );

  uuid_field_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_item        (in_item),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_item       (out_item),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random pops, or a long stall when the stimulus asks for one.
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) begin
          @(negedge clk);
          out_pop <= 1'b0;
        end
      end else begin
        out_pop <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  task automatic send_char(input logic [7:0] code, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= '{char_code: code, first_char: first};
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [3:0] pick_nibble();
    case ($urandom_range(9))
      0:       return 4'h0;
      1:       return 4'hf;
      2:       return 4'h9;
      3:       return 4'ha;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  // Characters just outside the digit ranges, or any byte at all.
  function automatic logic [7:0] bad_char();
    case ($urandom_range(7))
      0:       return 8'h2f;
      1:       return 8'h3a;
      2:       return 8'h40;
      3:       return 8'h47;
      4:       return 8'h60;
      5:       return 8'h67;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_uuid(input str_kind_t kind);
    logic [7:0] text [UUID_LEN];
    int         fill;
    int         cut_len;
    int         p;
    fill = $urandom_range(19);
    for (p = 0; p < UUID_LEN; p++) begin
      if (p == 8 || p == 13 || p == 18 || p == 23) begin
        text[p] = DASH_CHAR;
      end else if (p == UUID_LEN - 1) begin
        text[p] = NUL_CHAR;
      end else begin
        text[p] = hex_char(fill == 0 ? 4'h0 : fill == 1 ? 4'hf : pick_nibble());
      end
    end
    cut_len = UUID_LEN;
    case (kind)
      STR_BAD_CHAR: begin
        repeat ($urandom_range(1, 3)) text[$urandom_range(UUID_LEN - 2)] = bad_char();
      end
      STR_BAD_END:  text[UUID_LEN - 1] = 8'($urandom_range(1, 255));
      STR_CUT:      cut_len = $urandom_range(1, UUID_LEN - 1);
      default: ;
    endcase
    for (p = 0; p < cut_len; p++) send_char(text[p], p == 0);
    chars_sent += cut_len;
    // Characters after the terminator are dropped by the parser.
    if (kind != STR_CUT && $urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic run_strings(input int count);
    int        stop_at;
    int        r;
    str_kind_t kind;
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) begin
      r = $urandom_range(99);
      kind = r < 70 ? STR_GOOD : r < 82 ? STR_BAD_CHAR : r < 90 ? STR_BAD_END : STR_CUT;
      send_uuid(kind);
    end
  endtask

  task automatic wait_results_done();
    in_push <= 1'b0;
    wait (pending_results == 0);
    @(negedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_item       = '0;
    hold_req      = 1'b0;
    chars_sent    = 0;
    send_idle_pct = 0;
    take_idle_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Characters outside a string, then a string restarted while busy.
    send_char(8'hff, 1'b0);
    send_char(NUL_CHAR, 1'b0);
    send_char(8'h46, 1'b1);
    send_char(8'h61, 1'b0);
    send_char(DASH_CHAR, 1'b0);
    send_char(8'hff, 1'b1);
    send_char(8'h80, 1'b0);
    send_char(8'h39, 1'b1);
    send_char(8'h30, 1'b0);

    send_idle_pct = 17;
    take_idle_pct = 88;
    run_strings(PHASE_CHARS);
    wait_results_done();

    send_idle_pct = 88;
    take_idle_pct = 17;
    run_strings(PHASE_CHARS);
    wait_results_done();

    // Stall the result side long enough for the parser to fill up.
    send_idle_pct = 0;
    take_idle_pct = 0;
    hold_req = 1'b1;
    repeat (6) send_uuid(STR_GOOD);
    run_strings(PHASE_CHARS);
    wait_results_done();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/utp_pkg.sv
hw/rtl/utp_fifo.sv
hw/rtl/utp_front.sv
hw/rtl/utp_back.sv
hw/rtl/uuid_text_parser.sv
verif/uuid_field_checker.sv
verif/uuid_text_parser_tb.sv
